### hdl/ofs_pkg.sv
// Shared types and constants for the operand fetch sequencer.
package ofs_pkg;

  localparam logic [15:0] HIGH_PAGE = 16'hFF00;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_BYTE1 = 2'd1;
  localparam logic [1:0] PH_BYTE2 = 2'd2;
  localparam logic [1:0] PH_BYTE3 = 2'd3;

  localparam logic OP_START = 1'b0;
  localparam logic OP_BYTE  = 1'b1;

  typedef enum logic [4:0] {
    M_IMP    = 5'd0,
    M_R_D16  = 5'd1,
    M_R_R    = 5'd2,
    M_MR_R   = 5'd3,
    M_R      = 5'd4,
    M_R_D8   = 5'd5,
    M_R_MR   = 5'd6,
    M_R_HLI  = 5'd7,
    M_R_HLD  = 5'd8,
    M_HLI_R  = 5'd9,
    M_HLD_R  = 5'd10,
    M_R_A8   = 5'd11,
    M_A8_R   = 5'd12,
    M_HL_SPR = 5'd13,
    M_D16    = 5'd14,
    M_D8     = 5'd15,
    M_D16_R  = 5'd16,
    M_MR_D8  = 5'd17,
    M_MR     = 5'd18,
    M_A16_R  = 5'd19,
    M_R_A16  = 5'd20
  } mode_t;

  typedef struct packed {
    logic        operation;
    logic [4:0]  mode;
    logic [15:0] first_reg_value;
    logic [15:0] second_reg_value;
    logic        first_reg_is_c;
    logic        second_reg_is_c;
    logic [15:0] pc_value;
    logic [15:0] hl_value;
    logic [7:0]  read_byte;
  } in_t;

  typedef struct packed {
    logic        result_kind;
    logic [15:0] read_address;
    logic [15:0] operand_data;
    logic [15:0] memory_target;
    logic        target_is_memory;
    logic [15:0] next_pc;
    logic [15:0] next_hl;
    logic        hl_changed;
    logic [1:0]  extra_cycles;
    logic        bad_mode;
  } out_t;

  typedef struct packed {
    logic        is_byte;
    logic        needs_read;
    logic        bad;
    logic [15:0] start_addr;
    in_t         item;
  } cmd_t;

endpackage

### hdl/cpu_operand_fetch_sequencer.sv
// A request passes the front-end register and the queue; its result is registered.
// Throughput: one request per cycle, one queue pop per cycle, while out_stall is low.
// A request that causes no result leaves the queue without using the output.
// The queue holds two classified requests between the front and back ends.
// Synchronous active-low reset clears the queue, the fetch phase and the valid flags.
module cpu_operand_fetch_sequencer (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  ofs_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output ofs_pkg::out_t out_data
);
  import ofs_pkg::*;

  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic pop;
  logic q_not_empty;
  cmd_t head_cmd;

  ofs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .push     (push),
    .push_cmd (push_cmd),
    .q_full   (q_full)
  );

  ofs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .head_cmd  (head_cmd)
  );

  ofs_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .head_cmd    (head_cmd),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

### hdl/ofs_front.sv
// Front end: accepts requests and classifies their addressing mode.
module ofs_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  ofs_pkg::in_t  in_data,
  output logic          push,
  output ofs_pkg::cmd_t push_cmd,
  input  logic          q_full
);
  import ofs_pkg::*;

  logic vld_r;
  logic vld_nxt;
  in_t  item_r;
  logic accept;

  assign in_stall = vld_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign push     = vld_r && !q_full;

  always_comb begin
    vld_nxt = vld_r;
    if (push) begin
      vld_nxt = 1'b0;
    end
    if (accept) begin
      vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    if (accept) begin
      item_r <= in_data;
    end
  end

  always_comb begin
    push_cmd            = '0;
    push_cmd.item       = item_r;
    push_cmd.is_byte    = (item_r.operation == OP_BYTE);
    push_cmd.start_addr = item_r.pc_value;
    case (item_r.mode)
      M_IMP, M_R, M_R_R, M_MR_R, M_HLI_R, M_HLD_R: begin
        push_cmd.needs_read = 1'b0;
      end
      M_R_D8, M_R_A8, M_A8_R, M_HL_SPR, M_D8, M_MR_D8,
      M_R_D16, M_D16, M_D16_R, M_A16_R, M_R_A16: begin
        push_cmd.needs_read = 1'b1;
      end
      M_R_MR: begin
        push_cmd.needs_read = 1'b1;
        push_cmd.start_addr = item_r.second_reg_is_c ?
                              (item_r.second_reg_value | HIGH_PAGE) :
                              item_r.second_reg_value;
      end
      M_R_HLI, M_R_HLD: begin
        push_cmd.needs_read = 1'b1;
        push_cmd.start_addr = item_r.second_reg_value;
      end
      M_MR: begin
        push_cmd.needs_read = 1'b1;
        push_cmd.start_addr = item_r.first_reg_value;
      end
      default: begin
        push_cmd.bad = 1'b1;
      end
    endcase
  end

endmodule

### hdl/ofs_queue.sv
// Short queue of classified requests between the front and back ends.
module ofs_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ofs_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output ofs_pkg::cmd_t head_cmd
);
  import ofs_pkg::*;

  cmd_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r;
  logic [QCNT_W-1:0] count_nxt;

  assign full      = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head_cmd  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

### hdl/ofs_back.sv
// Back end: fetch sequencing state and the registered result stage.
module ofs_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_not_empty,
  input  ofs_pkg::cmd_t head_cmd,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output ofs_pkg::out_t out_data
);
  import ofs_pkg::*;

  logic [1:0]  phase_r;
  logic [1:0]  phase_nxt;
  logic [4:0]  mode_r;
  logic [4:0]  mode_nxt;
  logic [15:0] pc_r;
  logic [15:0] pc_nxt;
  logic [15:0] r1_r;
  logic [15:0] r1_nxt;
  logic [15:0] r2_r;
  logic [15:0] r2_nxt;
  logic [15:0] hl_r;
  logic [15:0] hl_nxt;
  logic [7:0]  low_r;
  logic [7:0]  low_nxt;
  logic        out_valid_r;
  logic        out_valid_nxt;
  out_t        out_data_r;
  out_t        res;
  logic        has_res;
  in_t         it;
  logic [15:0] word;
  logic [7:0]  b;

  assign pop       = q_not_empty && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign it        = head_cmd.item;
  assign b         = it.read_byte;
  assign word      = {b, low_r};

  always_comb begin
    phase_nxt = phase_r;
    mode_nxt  = mode_r;
    pc_nxt    = pc_r;
    r1_nxt    = r1_r;
    r2_nxt    = r2_r;
    hl_nxt    = hl_r;
    low_nxt   = low_r;
    has_res   = 1'b0;
    res       = '0;
    if (pop && !head_cmd.is_byte) begin
      mode_nxt  = it.mode;
      pc_nxt    = it.pc_value;
      r1_nxt    = it.first_reg_value;
      r2_nxt    = it.second_reg_value;
      hl_nxt    = it.hl_value;
      phase_nxt = PH_IDLE;
      has_res   = 1'b1;
      if (head_cmd.needs_read) begin
        phase_nxt        = PH_BYTE1;
        res.read_address = head_cmd.start_addr;
      end else begin
        res.result_kind = 1'b1;
        res.next_pc     = it.pc_value;
        res.next_hl     = it.hl_value;
        res.bad_mode    = head_cmd.bad;
        case (it.mode)
          M_R: begin
            res.operand_data = it.first_reg_value;
          end
          M_R_R: begin
            res.operand_data = it.second_reg_value;
          end
          M_MR_R: begin
            res.operand_data     = it.second_reg_value;
            res.memory_target    = it.first_reg_is_c ?
                                   (it.first_reg_value | HIGH_PAGE) : it.first_reg_value;
            res.target_is_memory = 1'b1;
          end
          M_HLI_R, M_HLD_R: begin
            res.operand_data     = it.second_reg_value;
            res.memory_target    = it.first_reg_value;
            res.target_is_memory = 1'b1;
            res.hl_changed       = 1'b1;
            res.next_hl          = (it.mode == M_HLI_R) ? it.hl_value + 16'd1 :
                                                          it.hl_value - 16'd1;
          end
          default: begin
          end
        endcase
      end
    end else if (pop && phase_r != PH_IDLE) begin
      phase_nxt        = PH_IDLE;
      has_res          = 1'b1;
      res.result_kind  = 1'b1;
      res.next_pc      = pc_r;
      res.next_hl      = hl_r;
      res.operand_data = {8'd0, b};
      res.extra_cycles = 2'd1;
      case (phase_r)
        PH_BYTE1: begin
          case (mode_r)
            M_R_D8, M_R_A8, M_HL_SPR, M_D8: begin
              res.next_pc = pc_r + 16'd1;
            end
            M_A8_R: begin
              res.next_pc          = pc_r + 16'd1;
              res.operand_data     = '0;
              res.memory_target    = {8'd0, b} | HIGH_PAGE;
              res.target_is_memory = 1'b1;
            end
            M_MR_D8: begin
              res.next_pc          = pc_r + 16'd1;
              res.memory_target    = r1_r;
              res.target_is_memory = 1'b1;
            end
            M_R_MR: begin
            end
            M_R_HLI: begin
              res.next_hl    = hl_r + 16'd1;
              res.hl_changed = 1'b1;
            end
            M_R_HLD: begin
              res.next_hl    = hl_r - 16'd1;
              res.hl_changed = 1'b1;
            end
            M_MR: begin
              res.memory_target    = r1_r;
              res.target_is_memory = 1'b1;
            end
            M_R_D16, M_D16, M_D16_R, M_A16_R, M_R_A16: begin
              low_nxt          = b;
              phase_nxt        = PH_BYTE2;
              res              = '0;
              res.read_address = pc_r + 16'd1;
            end
            default: begin
              has_res = 1'b0;
            end
          endcase
        end
        PH_BYTE2: begin
          res.next_pc      = pc_r + 16'd2;
          res.extra_cycles = 2'd2;
          res.operand_data = word;
          case (mode_r)
            M_R_D16, M_D16: begin
            end
            M_D16_R, M_A16_R: begin
              res.operand_data     = r2_r;
              res.memory_target    = word;
              res.target_is_memory = 1'b1;
            end
            M_R_A16: begin
              phase_nxt        = PH_BYTE3;
              res              = '0;
              res.read_address = word;
            end
            default: begin
              has_res = 1'b0;
            end
          endcase
        end
        PH_BYTE3: begin
          res.next_pc      = pc_r + 16'd2;
          res.extra_cycles = 2'd2;
          has_res          = (mode_r == M_R_A16);
        end
        default: begin
          has_res = 1'b0;
        end
      endcase
    end

    out_valid_nxt = out_valid_r && out_stall;
    if (has_res) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      mode_r      <= '0;
      pc_r        <= '0;
      r1_r        <= '0;
      r2_r        <= '0;
      hl_r        <= '0;
      low_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      mode_r      <= mode_nxt;
      pc_r        <= pc_nxt;
      r1_r        <= r1_nxt;
      r2_r        <= r2_nxt;
      hl_r        <= hl_nxt;
      low_r       <= low_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (has_res) begin
      out_data_r <= res;
    end
  end

endmodule
